// ===== rtl/ptim_pkg.sv =====
// Package for the prescaled compare interrupt timer.
// Holds the register offsets, command codes and item structs shared by all modules.
// No dependencies.
`default_nettype none

package ptim_pkg;

  // Command carried with each input transfer.
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2
  } ptim_op_t;

  // Byte offsets of the bus registers.
  localparam logic [7:0] OFS_CONTROL  = 8'h00;
  localparam logic [7:0] OFS_SOURCE   = 8'h0C;
  localparam logic [7:0] OFS_FREE     = 8'h10;
  localparam logic [7:0] OFS_PRESCALE = 8'h14;
  localparam logic [7:0] OFS_PRE_CMP  = 8'h18;
  localparam logic [7:0] OFS_COMPARE  = 8'h50;
  localparam logic [7:0] OFS_STEP     = 8'h54;
  localparam logic [7:0] OFS_SET_EN   = 8'h80;
  localparam logic [7:0] OFS_CLR_EN   = 8'h84;
  localparam logic [7:0] OFS_FLAG     = 8'h88;

  // One input item as held in the input register.
  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  reg_offset;
    logic [31:0] write_data;
  } ptim_item_t;

  // One result item as held in the output register.
  typedef struct packed {
    logic        irq_out;
    logic [31:0] read_data;
  } ptim_result_t;

endpackage

`default_nettype wire

// ===== rtl/ptim_core.sv =====
// Timer state and register file of the prescaled compare interrupt timer.
// Executes one tick, read or write per enabled cycle; depends on ptim_pkg.
`default_nettype none

module ptim_core
  import ptim_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         exec_en,
  input  wire ptim_item_t   item,
  output ptim_result_t      result
);

  logic        count_enable;
  logic [31:0] compare_source_select;
  logic [31:0] free_count;
  logic [31:0] prescale_count;
  logic [31:0] prescale_compare;
  logic [31:0] compare_value;
  logic [31:0] compare_step;
  logic        interrupt_enable;
  logic        interrupt_flag;

  logic        count_enable_next;
  logic [31:0] compare_source_select_next;
  logic [31:0] free_count_next;
  logic [31:0] prescale_count_next;
  logic [31:0] prescale_compare_next;
  logic [31:0] compare_value_next;
  logic [31:0] compare_step_next;
  logic        interrupt_enable_next;
  logic        interrupt_flag_next;

  logic [31:0] prescale_inc;
  logic [31:0] free_inc;
  logic [31:0] compare_adv;
  logic        prescale_hit;
  logic        compare_hit;
  logic [31:0] read_value;

  // The three adds and both compares run side by side; the tick then only selects.
  assign prescale_inc = prescale_count + 32'd1;
  assign free_inc     = free_count + 32'd1;
  assign compare_adv  = compare_value + compare_step;
  assign prescale_hit = (prescale_inc == prescale_compare);
  assign compare_hit  = (free_inc == compare_value);

  // Register read decode; undecoded offsets read zero.
  always_comb begin
    unique case (item.reg_offset)
      OFS_CONTROL:  read_value = {31'd0, count_enable};
      OFS_SOURCE:   read_value = compare_source_select;
      OFS_FREE:     read_value = free_count;
      OFS_PRESCALE: read_value = prescale_count;
      OFS_PRE_CMP:  read_value = prescale_compare;
      OFS_COMPARE:  read_value = compare_value;
      OFS_STEP:     read_value = compare_step;
      OFS_SET_EN:   read_value = {31'd0, interrupt_enable};
      OFS_CLR_EN:   read_value = {31'd0, interrupt_enable};
      OFS_FLAG:     read_value = {31'd0, interrupt_flag};
      default:      read_value = 32'd0;
    endcase
  end

  // Next state for the current item.
  always_comb begin
    count_enable_next          = count_enable;
    compare_source_select_next = compare_source_select;
    free_count_next            = free_count;
    prescale_count_next        = prescale_count;
    prescale_compare_next      = prescale_compare;
    compare_value_next         = compare_value;
    compare_step_next          = compare_step;
    interrupt_enable_next      = interrupt_enable;
    interrupt_flag_next        = interrupt_flag;
    unique case (item.opcode)
      OP_TICK: begin
        if (count_enable) begin
          if (prescale_hit) begin
            prescale_count_next = 32'd0;
            free_count_next     = free_inc;
            if (compare_hit) begin
              interrupt_flag_next = 1'b1;
              compare_value_next  = compare_adv;
            end
          end else begin
            prescale_count_next = prescale_inc;
          end
        end
      end
      OP_WRITE: begin
        unique case (item.reg_offset)
          OFS_CONTROL:  count_enable_next = item.write_data[0];
          OFS_SOURCE:   compare_source_select_next = item.write_data;
          OFS_FREE:     free_count_next = item.write_data;
          OFS_PRESCALE: prescale_count_next = item.write_data;
          OFS_PRE_CMP:  prescale_compare_next = item.write_data;
          OFS_COMPARE:  compare_value_next = item.write_data;
          OFS_STEP:     compare_step_next = item.write_data;
          OFS_SET_EN: begin
            if (item.write_data[0]) interrupt_enable_next = 1'b1;
          end
          OFS_CLR_EN: begin
            if (item.write_data[0]) interrupt_enable_next = 1'b0;
          end
          OFS_FLAG: begin
            if (item.write_data[0]) interrupt_flag_next = 1'b0;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // Result of the current item: read data only for reads, line after the update.
  always_comb begin
    result.read_data = (item.opcode == OP_READ) ? read_value : 32'd0;
    result.irq_out   = interrupt_flag_next & interrupt_enable_next;
  end

  // State registers, committed when the item moves to the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      count_enable          <= 1'b0;
      compare_source_select <= 32'd0;
      free_count            <= 32'd0;
      prescale_count        <= 32'd0;
      prescale_compare      <= 32'd0;
      compare_value         <= 32'd0;
      compare_step          <= 32'd0;
      interrupt_enable      <= 1'b0;
      interrupt_flag        <= 1'b0;
    end else if (exec_en) begin
      count_enable          <= count_enable_next;
      compare_source_select <= compare_source_select_next;
      free_count            <= free_count_next;
      prescale_count        <= prescale_count_next;
      prescale_compare      <= prescale_compare_next;
      compare_value         <= compare_value_next;
      compare_step          <= compare_step_next;
      interrupt_enable      <= interrupt_enable_next;
      interrupt_flag        <= interrupt_flag_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/prescaled_compare_interrupt_timer.sv =====
// Top level of the prescaled compare interrupt timer: input register, output register.
// Instantiates ptim_core; depends on ptim_pkg.
//
// Usage: each transfer on the s_ stream is one command. s_tuser carries the opcode
// (tick, register read or register write), s_tdata the register offset and write
// data. Every command produces exactly one transfer on the m_ stream carrying the
// read data (zero for ticks and writes) and the interrupt line as it stands after
// the command.
// Path: an accepted command waits in the input register, then passes through the timer
// logic into the output register, which drives m_, once that register is free or being emptied.
// Throughput: one command per cycle; the input register feeds the timer logic
// straight into the output register, so a new command is taken every cycle the
// output register is free or being emptied.
// Reset: rst is synchronous and clears all timer registers and both stage valids.
// Stall: while m_tready is low with a result waiting, one more command is held in
// the input register, then s_tready drops until the result is taken.
`default_nettype none

module prescaled_compare_interrupt_timer
  import ptim_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // [7:0] reg_offset, [39:8] write_data
  input  wire logic [1:0]  s_tuser,   // [1:0] opcode
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata    // [31:0] read_data, [32] irq_out, [39:33] zero
);

  logic         in_valid;
  ptim_item_t   in_item;
  logic         out_valid;
  ptim_result_t out_result;
  ptim_result_t core_result;
  logic         advance;

  // An item moves forward when the output register is free or being drained.
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.opcode     <= s_tuser;
      in_item.reg_offset <= s_tdata[7:0];
      in_item.write_data <= s_tdata[39:8];
    end
  end

  ptim_core u_core (
    .clk     (clk),
    .rst     (rst),
    .exec_en (advance),
    .item    (in_item),
    .result  (core_result)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= core_result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {7'd0, out_result.irq_out, out_result.read_data};

  // An empty input register always takes a transfer.
  a_ready_when_empty : assert property (@(posedge clk) disable iff (rst)
    !in_valid |-> s_tready)
    else $error("input register empty but s_tready low");

  // A command leaving the input register always lands in the output register.
  a_advance_fills_out : assert property (@(posedge clk) disable iff (rst)
    advance |=> m_tvalid)
    else $error("executed command did not produce a result");

  // Only reads return nonzero data.
  a_nonread_zero : assert property (@(posedge clk) disable iff (rst)
    (advance && (in_item.opcode != OP_READ)) |=> (m_tdata[31:0] == 32'd0))
    else $error("non-read command returned nonzero read data");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the prescaled compare interrupt timer.
// A directed table, then weighted random ticks and register accesses, are checked against an
// in-bench timer model under random stalls on both streams. Depends on ptim_pkg and the RTL top.
`default_nettype none

module tb_top
  import ptim_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CLK_PERIOD   = 8;
  localparam int          RANDOM_ITEMS = 900;
  localparam int          CALM_ITEMS   = 150;   // no idling on either side for the tail
  localparam int          PRESSURE_AT  = 300;   // transfer count that starts the long hold-off
  localparam int          HOLD_CYCLES  = 60;
  localparam int          DRAIN_CYCLES = 8;
  localparam int          MAX_REPORTS  = 40;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam logic [1:0]  OP_UNUSED    = 2'd3;  // opcode that the block must ignore

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;   // [7:0] reg_offset, [39:8] write_data
  logic [1:0]  s_tuser;   // [1:0] opcode
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;   // [31:0] read_data, [32] irq_out, [39:33] zero

  prescaled_compare_interrupt_timer i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Timer state as the testbench tracks it.
  logic        run_bit;
  logic [31:0] source_word;
  logic [31:0] free_ticks;
  logic [31:0] pre_ticks;
  logic [31:0] pre_limit;
  logic [31:0] match_value;
  logic [31:0] match_step;
  logic        irq_enable_bit;
  logic        irq_pending;

  ptim_result_t results_due[$];
  int           error_count  = 0;
  int           result_count = 0;
  int           sent_count   = 0;
  bit           calm         = 1'b0;
  bit           hold_request = 1'b0;
  int unsigned  cycle_count  = 0;

  // One row of the directed table; want_* is used only where typed is set.
  typedef struct {
    logic [1:0]  op;
    logic [7:0]  ofs;
    logic [31:0] data;
    bit          typed;
    logic [31:0] want_read;
    logic        want_irq;
  } timer_row_t;

  localparam int DIRECTED_ROWS = 28;
  timer_row_t directed_rows [DIRECTED_ROWS] = '{
    // Values straight after reset, a tick while counting is off, and a source write read back.
    '{OP_READ,   OFS_CONTROL,  32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0},
    '{OP_TICK,   OFS_CONTROL,  32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0},
    '{OP_READ,   OFS_PRESCALE, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0},
    '{OP_WRITE,  OFS_SOURCE,   32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 1'b0},
    '{OP_READ,   OFS_SOURCE,   32'h0000_0000, 1'b1, 32'hFFFF_FFFF, 1'b0},
    // Only bit 0 of the control word counts.
    '{OP_WRITE,  OFS_CONTROL,  32'hFFFF_FFFE, 1'b1, 32'h0000_0000, 1'b0},
    '{OP_WRITE,  OFS_CONTROL,  32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 1'b0},
    '{OP_READ,   OFS_CONTROL,  32'h0000_0000, 1'b1, 32'h0000_0001, 1'b0},
    // Prescale compare of zero matches only when the prescale count wraps.
    '{OP_WRITE,  OFS_PRESCALE, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0},
    '{OP_WRITE,  OFS_COMPARE,  32'h0000_0001, 1'b0, 32'h0, 1'b0},
    '{OP_WRITE,  OFS_STEP,     32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0},
    '{OP_TICK,   OFS_CONTROL,  32'h0000_0000, 1'b0, 32'h0, 1'b0},
    '{OP_READ,   OFS_FLAG,     32'h0000_0000, 1'b0, 32'h0, 1'b0},
    // Writes with bit 0 clear leave the enable and flag alone; one set-enable write turns the enable on.
    '{OP_WRITE,  OFS_SET_EN,   32'hFFFF_FFFE, 1'b0, 32'h0, 1'b0},
    '{OP_WRITE,  OFS_SET_EN,   32'h0000_0001, 1'b0, 32'h0, 1'b0},
    '{OP_WRITE,  OFS_FLAG,     32'hFFFF_FFFE, 1'b0, 32'h0, 1'b0},
    '{OP_WRITE,  OFS_CLR_EN,   32'h0000_0000, 1'b0, 32'h0, 1'b0},
    // Unused opcode and undecoded offsets, then a compare read and a flag clear.
    '{OP_UNUSED, OFS_FLAG,     32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0},
    '{OP_READ,   8'hFF,        32'h0000_0000, 1'b0, 32'h0, 1'b0},
    '{OP_WRITE,  8'h04,        32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0},
    '{OP_READ,   OFS_COMPARE,  32'h0000_0000, 1'b0, 32'h0, 1'b0},
    '{OP_WRITE,  OFS_FLAG,     32'h0000_0001, 1'b0, 32'h0, 1'b0},
    // Free count wraps onto a compare value of zero; the compare value wraps too.
    '{OP_WRITE,  OFS_PRE_CMP,  32'h0000_0001, 1'b0, 32'h0, 1'b0},
    '{OP_WRITE,  OFS_FREE,     32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0},
    '{OP_TICK,   OFS_CONTROL,  32'h0000_0000, 1'b0, 32'h0, 1'b0},
    '{OP_READ,   OFS_COMPARE,  32'h0000_0000, 1'b0, 32'h0, 1'b0},
    '{OP_WRITE,  OFS_CLR_EN,   32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0},
    '{OP_READ,   OFS_SET_EN,   32'h0000_0000, 1'b0, 32'h0, 1'b0}
  };

  // Applies one command to the tracked timer state and returns the result it should produce.
  function automatic ptim_result_t advance_timer(ptim_item_t cmd);
    ptim_result_t res;
    res.read_data = '0;
    case (cmd.opcode)
      OP_TICK: begin
        if (run_bit) begin
          pre_ticks = pre_ticks + 32'd1;
          if (pre_ticks == pre_limit) begin
            pre_ticks  = '0;
            free_ticks = free_ticks + 32'd1;
            if (free_ticks == match_value) begin
              irq_pending = 1'b1;
              match_value = match_value + match_step;
            end
          end
        end
      end
      OP_READ: begin
        case (cmd.reg_offset)
          OFS_CONTROL:  res.read_data = {31'd0, run_bit};
          OFS_SOURCE:   res.read_data = source_word;
          OFS_FREE:     res.read_data = free_ticks;
          OFS_PRESCALE: res.read_data = pre_ticks;
          OFS_PRE_CMP:  res.read_data = pre_limit;
          OFS_COMPARE:  res.read_data = match_value;
          OFS_STEP:     res.read_data = match_step;
          OFS_SET_EN:   res.read_data = {31'd0, irq_enable_bit};
          OFS_CLR_EN:   res.read_data = {31'd0, irq_enable_bit};
          OFS_FLAG:     res.read_data = {31'd0, irq_pending};
          default:      res.read_data = '0;
        endcase
      end
      OP_WRITE: begin
        case (cmd.reg_offset)
          OFS_CONTROL:  run_bit     = cmd.write_data[0];
          OFS_SOURCE:   source_word = cmd.write_data;
          OFS_FREE:     free_ticks  = cmd.write_data;
          OFS_PRESCALE: pre_ticks   = cmd.write_data;
          OFS_PRE_CMP:  pre_limit   = cmd.write_data;
          OFS_COMPARE:  match_value = cmd.write_data;
          OFS_STEP:     match_step  = cmd.write_data;
          OFS_SET_EN:   if (cmd.write_data[0]) irq_enable_bit = 1'b1;
          OFS_CLR_EN:   if (cmd.write_data[0]) irq_enable_bit = 1'b0;
          OFS_FLAG:     if (cmd.write_data[0]) irq_pending = 1'b0;
          default: ;
        endcase
      end
      default: ;
    endcase
    res.irq_out = irq_pending & irq_enable_bit;
    return res;
  endfunction

  function automatic logic [7:0] mapped_offset(int unsigned idx);
    case (idx)
      0:       return OFS_CONTROL;
      1:       return OFS_SOURCE;
      2:       return OFS_FREE;
      3:       return OFS_PRESCALE;
      4:       return OFS_PRE_CMP;
      5:       return OFS_COMPARE;
      6:       return OFS_STEP;
      7:       return OFS_SET_EN;
      8:       return OFS_CLR_EN;
      default: return OFS_FLAG;
    endcase
  endfunction

  // Weighted random command. Register writes are steered so the free count keeps
  // running into the compare value, which makes interrupts frequent.
  function automatic ptim_item_t random_command();
    ptim_item_t  cmd;
    int unsigned pick;
    pick           = $urandom_range(0, 99);
    cmd.opcode     = OP_TICK;
    cmd.reg_offset = 8'($urandom);
    cmd.write_data = $urandom;
    if (pick < 50) begin
      cmd.opcode = OP_TICK;
    end else if (pick < 65) begin
      cmd.opcode = OP_READ;
      if ($urandom_range(0, 4) != 0) cmd.reg_offset = mapped_offset($urandom_range(0, 9));
    end else if (pick < 93) begin
      cmd.opcode     = OP_WRITE;
      cmd.reg_offset = mapped_offset($urandom_range(0, 9));
      case (cmd.reg_offset)
        OFS_CONTROL: cmd.write_data[0] = ($urandom_range(0, 9) != 0);
        OFS_FREE: begin
          if ($urandom_range(0, 1)) cmd.write_data = match_value - $urandom_range(1, 6);
        end
        OFS_PRESCALE: if ($urandom_range(0, 7) != 0) cmd.write_data = '0;
        OFS_PRE_CMP:  if ($urandom_range(0, 7) != 0) cmd.write_data = $urandom_range(1, 4);
        OFS_COMPARE: begin
          if ($urandom_range(0, 3) != 0) cmd.write_data = free_ticks + $urandom_range(1, 6);
        end
        OFS_STEP: if ($urandom_range(0, 3) != 0) cmd.write_data = $urandom_range(0, 8);
        default: ;
      endcase
    end else if (pick < 97) begin
      // Any offset, any data.
      cmd.opcode = OP_WRITE;
    end else begin
      cmd.opcode = OP_UNUSED;
    end
    return cmd;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("MISMATCH result %0d: %s got 0x%08h expected 0x%08h",
               result_count, what, got, want);
    end
  endtask

  // Offers one command, waits for its transfer, and queues the result it must produce.
  task automatic send_command(input ptim_item_t cmd, input bit typed, input ptim_result_t want);
    int           gap;
    ptim_result_t predicted;
    gap = (!calm && $urandom_range(0, 3) == 0) ? int'($urandom_range(1, 14)) : 0;
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {cmd.write_data, cmd.reg_offset};
    s_tuser  <= cmd.opcode;
    do @(posedge clk); while (!s_tready);
    predicted = advance_timer(cmd);
    results_due.push_back(typed ? want : predicted);
    sent_count++;
    if (sent_count == PRESSURE_AT) hold_request = 1'b1;
  endtask

  // Stimulus and end of run.
  initial begin
    ptim_item_t   cmd;
    ptim_result_t want;
    run_bit        = 1'b0;
    source_word    = '0;
    free_ticks     = '0;
    pre_ticks      = '0;
    pre_limit      = '0;
    match_value    = '0;
    match_step     = '0;
    irq_enable_bit = 1'b0;
    irq_pending    = 1'b0;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      cmd.opcode     = directed_rows[i].op;
      cmd.reg_offset = directed_rows[i].ofs;
      cmd.write_data = directed_rows[i].data;
      want.read_data = directed_rows[i].want_read;
      want.irq_out   = directed_rows[i].want_irq;
      send_command(cmd, directed_rows[i].typed, want);
    end

    want = '0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
      send_command(random_command(), 1'b0, want);
    end
    @(negedge clk);
    s_tvalid <= 1'b0;

    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && results_due.size() == 0) begin
      $display("prescaled_compare_interrupt_timer verification clean");
    end else begin
      $display("prescaled_compare_interrupt_timer verification failed");
    end
    $finish;
  end

  // Result receiver: random ready bursts, one long hold-off, steady ready at the tail.
  initial begin
    logic rdy;
    int   len;
    bit   held;
    held = 1'b0;
    m_tready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request && !held) begin
        rdy  = 1'b0;
        len  = HOLD_CYCLES;
        held = 1'b1;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        rdy = 1'b0;
        len = $urandom_range(1, 14);
      end else begin
        rdy = 1'b1;
        len = $urandom_range(1, 20);
      end
      m_tready <= rdy;
      repeat (len - 1) @(negedge clk);
    end
  end

  // Result checker.
  always @(posedge clk) begin
    ptim_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      result_count++;
      if (results_due.size() == 0) begin
        report_mismatch("unexpected result, data", m_tdata[31:0], 32'd0);
      end else begin
        want = results_due.pop_front();
        if (m_tdata[31:0] !== want.read_data) begin
          report_mismatch("read_data", m_tdata[31:0], want.read_data);
        end
        if (m_tdata[32] !== want.irq_out) begin
          report_mismatch("irq_out", {31'd0, m_tdata[32]}, {31'd0, want.irq_out});
        end
        if (m_tdata[39:33] !== 7'd0) begin
          report_mismatch("tdata padding", {25'd0, m_tdata[39:33]}, 32'd0);
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("prescaled_compare_interrupt_timer verification failed");
    $finish;
  end

endmodule

`default_nettype wire

// ===== prescaled_compare_interrupt_timer.f =====
rtl/ptim_pkg.sv
rtl/ptim_core.sv
rtl/prescaled_compare_interrupt_timer.sv
tb/tb_top.sv
